>>> hw/rtl/tpm_pkg.sv
// Shared types and constants for the touch raw to pixel map block.
package tpm_pkg;

  localparam int RAW_W   = 12;
  localparam int CAL_W   = 16;
  localparam int PIX_W   = 12;
  localparam int REM_W   = CAL_W + PIX_W;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 3'd6;

  localparam logic signed [CAL_W-1:0] RST_CAL_LOW  = 16'sd200;
  localparam logic signed [CAL_W-1:0] RST_CAL_HIGH = 16'sd3800;
  localparam logic [PIX_W-1:0]        RST_WIDTH    = 12'd320;
  localparam logic [PIX_W-1:0]        RST_HEIGHT   = 12'd240;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x_sample;
    logic [RAW_W-1:0] raw_y_sample;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } out_item_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] cal_x_left;
    logic signed [CAL_W-1:0] cal_x_right;
    logic signed [CAL_W-1:0] cal_y_top;
    logic signed [CAL_W-1:0] cal_y_bottom;
    logic                    swap_axes;
    logic [PIX_W-1:0]        panel_width;
    logic [PIX_W-1:0]        panel_height;
  } cfg_t;

  // One axis in flight through the divider: partial remainder, divisor, quotient so far.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [CAL_W-1:0] den;
    logic [PIX_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t x;
    div_lane_t y;
  } div_item_t;

endpackage

>>> hw/rtl/touch_raw_to_pixel_map.sv
// An accepted item passes the front clamp, multiply, twelve divider cells and the output
// register in that order, and its result may then wait on out_stall.
// Throughput: one item per cycle while out_stall is low; each divider cell settles one
// quotient bit of both axes, and the chain of twelve cells passes a new item along every cycle.
// Reset (synchronous, rst_n low) empties the pipeline and loads the calibration
// registers with 200/3800 per axis, no swap and a 320 by 240 panel.
module touch_raw_to_pixel_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tpm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tpm_pkg::out_item_t            out_data,
  input  logic                          cfg_wr_en,
  input  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int NCELL = tpm_pkg::PIX_W;

  tpm_pkg::cfg_t      cfg_r;
  logic               front_ready;
  logic               chain_valid [0:NCELL];
  logic               chain_ready [0:NCELL];
  tpm_pkg::div_item_t chain_data  [0:NCELL];
  logic               out_valid_r;
  tpm_pkg::out_item_t out_data_r;
  logic               out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_x_left   <= tpm_pkg::RST_CAL_LOW;
      cfg_r.cal_x_right  <= tpm_pkg::RST_CAL_HIGH;
      cfg_r.cal_y_top    <= tpm_pkg::RST_CAL_LOW;
      cfg_r.cal_y_bottom <= tpm_pkg::RST_CAL_HIGH;
      cfg_r.swap_axes    <= 1'b0;
      cfg_r.panel_width  <= tpm_pkg::RST_WIDTH;
      cfg_r.panel_height <= tpm_pkg::RST_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tpm_pkg::CFG_CAL_X_LEFT:   cfg_r.cal_x_left   <= cfg_wdata;
        tpm_pkg::CFG_CAL_X_RIGHT:  cfg_r.cal_x_right  <= cfg_wdata;
        tpm_pkg::CFG_CAL_Y_TOP:    cfg_r.cal_y_top    <= cfg_wdata;
        tpm_pkg::CFG_CAL_Y_BOTTOM: cfg_r.cal_y_bottom <= cfg_wdata;
        tpm_pkg::CFG_SWAP_AXES:    cfg_r.swap_axes    <= cfg_wdata[0];
        tpm_pkg::CFG_PANEL_WIDTH:  cfg_r.panel_width  <= cfg_wdata[tpm_pkg::PIX_W-1:0];
        tpm_pkg::CFG_PANEL_HEIGHT: cfg_r.panel_height <= cfg_wdata[tpm_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  tpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (front_ready),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_ready (chain_ready[0])
  );

  assign in_stall = !front_ready;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tpm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_data  (chain_data[k]),
      .up_ready (chain_ready[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_data  (chain_data[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  // The output register takes a new item when it is empty or its item is taken, so the
  // chain holds while a result waits on out_stall.
  assign out_ready          = !out_valid_r || !out_stall;
  assign chain_ready[NCELL] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= chain_valid[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && chain_valid[NCELL]) begin
      out_data_r.pixel_x <= chain_data[NCELL].x.quo;
      out_data_r.pixel_y <= chain_data[NCELL].y.quo;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // After the last cell the remainder must be below the divisor, else a quotient bit was lost.
  a_div_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    chain_valid[NCELL] |->
      (chain_data[NCELL].x.rem < (tpm_pkg::REM_W'(chain_data[NCELL].x.den) << NCELL)))
    else $error("x divider remainder not below divisor");

  a_div_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    chain_valid[NCELL] |->
      (chain_data[NCELL].y.rem < (tpm_pkg::REM_W'(chain_data[NCELL].y.den) << NCELL)))
    else $error("y divider remainder not below divisor");

  // A finished item in the last cell moves into an empty output register at once.
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_valid[NCELL] && !out_valid_r) |=> out_valid_r)
    else $error("output register did not take a finished item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

>>> hw/rtl/tpm_front.sv
// Front end: axis swap, clamp into the calibrated span, and the scaling multiply.
module tpm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tpm_pkg::cfg_t       cfg,
  input  logic                up_valid,
  input  tpm_pkg::in_item_t   up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output tpm_pkg::div_item_t  dn_data,
  input  logic                dn_ready
);

  typedef struct packed {
    logic [tpm_pkg::CAL_W-1:0] num;
    logic [tpm_pkg::CAL_W-1:0] den;
  } axis_prep_t;

  // The clamped raw value always lies between the two ends, so the scaled
  // result is |raw - end_a| * top / |end_b - end_a| and never needs a clamp.
  function automatic axis_prep_t prep_axis(
    input logic [tpm_pkg::RAW_W-1:0]        raw,
    input logic signed [tpm_pkg::CAL_W-1:0] end_a,
    input logic signed [tpm_pkg::CAL_W-1:0] end_b
  );
    logic signed [tpm_pkg::CAL_W+1:0] r, a, b, lo, hi, rc, diff, span, neg_diff, neg_span;
    axis_prep_t p;
    r    = {{(tpm_pkg::CAL_W+2-tpm_pkg::RAW_W){1'b0}}, raw};
    a    = {{2{end_a[tpm_pkg::CAL_W-1]}}, end_a};
    b    = {{2{end_b[tpm_pkg::CAL_W-1]}}, end_b};
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    rc   = (r < lo) ? lo : ((r > hi) ? hi : r);
    diff = rc - a;
    span = b - a;
    neg_diff = -diff;
    neg_span = -span;
    p.num = diff[tpm_pkg::CAL_W+1] ? neg_diff[tpm_pkg::CAL_W-1:0] : diff[tpm_pkg::CAL_W-1:0];
    if (span == '0) begin
      // Equal ends: a zero numerator over a unit divisor gives zero.
      p.den = tpm_pkg::CAL_W'(1);
    end else begin
      p.den = span[tpm_pkg::CAL_W+1] ? neg_span[tpm_pkg::CAL_W-1:0]
                                     : span[tpm_pkg::CAL_W-1:0];
    end
    return p;
  endfunction

  logic                       s1_valid_r;
  axis_prep_t                 s1_x_r, s1_y_r;
  logic [tpm_pkg::PIX_W-1:0]  s1_tx_r, s1_ty_r;
  logic                       s2_valid_r;
  tpm_pkg::div_item_t         s2_data_r;

  axis_prep_t                 px_nxt, py_nxt;
  logic [tpm_pkg::RAW_W-1:0]  ra, rb;
  logic                       s1_ready, s2_ready;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  always_comb begin
    ra = cfg.swap_axes ? up_data.raw_y_sample : up_data.raw_x_sample;
    rb = cfg.swap_axes ? up_data.raw_x_sample : up_data.raw_y_sample;
    px_nxt = prep_axis(ra, cfg.cal_x_left, cfg.cal_x_right);
    py_nxt = prep_axis(rb, cfg.cal_y_top, cfg.cal_y_bottom);
    if (cfg.panel_width == '0 || cfg.panel_height == '0) begin
      px_nxt.num = '0;
      py_nxt.num = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= up_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_x_r  <= px_nxt;
      s1_y_r  <= py_nxt;
      s1_tx_r <= cfg.panel_width - tpm_pkg::PIX_W'(1);
      s1_ty_r <= cfg.panel_height - tpm_pkg::PIX_W'(1);
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r.x.rem <= tpm_pkg::REM_W'(s1_x_r.num) * tpm_pkg::REM_W'(s1_tx_r);
      s2_data_r.x.den <= s1_x_r.den;
      s2_data_r.x.quo <= '0;
      s2_data_r.y.rem <= tpm_pkg::REM_W'(s1_y_r.num) * tpm_pkg::REM_W'(s1_ty_r);
      s2_data_r.y.den <= s1_y_r.den;
      s2_data_r.y.quo <= '0;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_data_r;

endmodule

>>> hw/rtl/tpm_div_cell.sv
// One divider cell: settles one quotient bit for both axes and passes the item on.
module tpm_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  tpm_pkg::div_item_t  up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output tpm_pkg::div_item_t  dn_data,
  input  logic                dn_ready
);

  // Restoring step against the divisor aligned to the top quotient bit; the
  // remainder shifts left so that every cell compares at the same place.
  function automatic tpm_pkg::div_lane_t div_step(input tpm_pkg::div_lane_t l);
    logic [tpm_pkg::REM_W-1:0] dd, diff;
    logic                      ge;
    tpm_pkg::div_lane_t        o;
    dd   = tpm_pkg::REM_W'(l.den) << (tpm_pkg::PIX_W - 1);
    ge   = (l.rem >= dd);
    diff = ge ? (l.rem - dd) : l.rem;
    o.rem = {diff[tpm_pkg::REM_W-2:0], 1'b0};
    o.den = l.den;
    o.quo = {l.quo[tpm_pkg::PIX_W-2:0], ge};
    return o;
  endfunction

  logic               valid_r;
  tpm_pkg::div_item_t data_r;

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r.x <= div_step(up_data.x);
      data_r.y <= div_step(up_data.y);
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
